// ----- sv/kdeg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package kdeg_pkg;

    localparam int KEY_W     = 3;
    localparam int KEY_SPACE = 8;
    localparam int KIND_W    = 3;
    localparam int EV_W      = 3;
    localparam int LVL_W     = 8;
    localparam int TMR_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    localparam logic [LVL_W-1:0] LVL_MAX = 8'hFF;
    localparam logic [TMR_W-1:0] TMR_MAX = 16'hFFFF;

    // key status codes
    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_PRESS   = 2'd1;
    localparam logic [1:0] ST_AUTOREP = 2'd2;
    localparam logic [1:0] ST_LONG    = 2'd3;

    // event codes
    localparam logic [EV_W-1:0] EV_DOWN   = 3'd0;
    localparam logic [EV_W-1:0] EV_UP     = 3'd1;
    localparam logic [EV_W-1:0] EV_REPEAT = 3'd2;
    localparam logic [EV_W-1:0] EV_LONG   = 3'd3;
    localparam logic [EV_W-1:0] EV_RIGHT  = 3'd4;
    localparam logic [EV_W-1:0] EV_LEFT   = 3'd5;

    // key kinds
    localparam logic [KIND_W-1:0] KIND_PLAIN   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_AUTOREP = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LONG    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ROT_CLK = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ROT_DAT = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AR_DELAY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AR_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LP_DELAY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KINDS     = 3'd5;

    localparam logic [LVL_W-1:0]     RST_UPPER     = 8'd192;
    localparam logic [LVL_W-1:0]     RST_LOWER     = 8'd64;
    localparam logic [TMR_W-1:0]     RST_AR_DELAY  = 16'd500;
    localparam logic [TMR_W-1:0]     RST_AR_PERIOD = 16'd100;
    localparam logic [TMR_W-1:0]     RST_LP_DELAY  = 16'd1000;
    localparam logic [CFG_DAT_W-1:0] RST_KINDS     = 24'd0;

    typedef struct packed {
        logic [KEY_W-1:0] key_number;
        logic             raw_pressed;
    } t_in_beat;

    typedef struct packed {
        logic [EV_W-1:0]  event_kind;
        logic [KEY_W-1:0] event_key;
    } t_out_beat;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [1:0]       status;
        logic [TMR_W-1:0] timer;
    } t_key_state;

    typedef struct packed {
        logic [LVL_W-1:0] upper;
        logic [LVL_W-1:0] lower;
        logic [TMR_W-1:0] ar_delay;
        logic [TMR_W-1:0] ar_period;
        logic [TMR_W-1:0] lp_delay;
    } t_cfg;

    typedef struct packed {
        logic            emit;
        logic [EV_W-1:0] kind;
    } t_upd_ev;

endpackage

`default_nettype wire

// ----- sv/kdeg_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kdeg_mem
    import kdeg_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr_a,
    input  wire logic [AW-1:0] i_rd_addr_b,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_key_state    i_wr_data,
    output t_key_state         o_rd_data_a,
    output logic [1:0]         o_rd_status_b
);

    t_key_state r_mem [DEPTH];
    logic [DEPTH-1:0] r_ent_vld;
    t_key_state r_rd_a;
    t_key_state r_rd_b;
    logic r_vld_a;
    logic r_vld_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    // entries never written read back as the reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
            r_vld_a   <= 1'b0;
            r_vld_b   <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_ent_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_vld_a <= r_ent_vld[i_rd_addr_a];
                r_vld_b <= r_ent_vld[i_rd_addr_b];
            end
        end
    end

    assign o_rd_data_a   = r_vld_a ? r_rd_a : '0;
    assign o_rd_status_b = r_vld_b ? r_rd_b.status : ST_IDLE;

endmodule

`default_nettype wire

// ----- sv/kdeg_update.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kdeg_update
    import kdeg_pkg::*;
(
    input  wire t_key_state        i_cur,
    input  wire logic              i_pressed,
    input  wire logic [KIND_W-1:0] i_kind,
    input  wire logic              i_has_next,
    input  wire logic              i_next_idle,
    input  wire t_cfg              i_cfg,
    output t_key_state             o_nxt,
    output t_upd_ev                o_ev
);

    logic [LVL_W-1:0] lvl;
    logic [TMR_W-1:0] t_inc;
    logic             rise;
    logic             fall;
    logic             is_idle;

    assign is_idle = (i_cur.status == ST_IDLE);

    // level moves a quarter of the way toward the rail
    always_comb begin
        if (i_pressed) begin
            lvl = i_cur.level + ((LVL_MAX - i_cur.level) >> 2);
        end else begin
            lvl = i_cur.level - (i_cur.level >> 2);
        end
    end

    assign rise  = is_idle && (lvl > i_cfg.upper);
    assign fall  = !is_idle && (lvl < i_cfg.lower);
    assign t_inc = (i_cur.timer == TMR_MAX) ? i_cur.timer : i_cur.timer + 16'd1;

    always_comb begin
        o_nxt       = i_cur;
        o_nxt.level = lvl;
        o_ev.emit   = 1'b0;
        o_ev.kind   = EV_DOWN;
        if (i_kind == KIND_PLAIN || i_kind == KIND_AUTOREP || i_kind == KIND_LONG) begin
            if (rise) begin
                o_ev.emit    = 1'b1;
                o_ev.kind    = EV_DOWN;
                o_nxt.timer  = '0;
                o_nxt.status = ST_PRESS;
            end else if (fall) begin
                // up only if no repeat or long event was given
                if (i_cur.status == ST_PRESS) begin
                    o_ev.emit = 1'b1;
                    o_ev.kind = EV_UP;
                end
                o_nxt.status = ST_IDLE;
            end else if (!is_idle) begin
                o_nxt.timer = t_inc;
                if (i_kind == KIND_AUTOREP) begin
                    if (i_cur.status == ST_PRESS && t_inc >= i_cfg.ar_delay) begin
                        o_ev.emit    = 1'b1;
                        o_ev.kind    = EV_REPEAT;
                        o_nxt.timer  = '0;
                        o_nxt.status = ST_AUTOREP;
                    end else if (i_cur.status == ST_AUTOREP && t_inc >= i_cfg.ar_period) begin
                        o_ev.emit   = 1'b1;
                        o_ev.kind   = EV_REPEAT;
                        o_nxt.timer = '0;
                    end
                end else if (i_kind == KIND_LONG) begin
                    if (i_cur.status == ST_PRESS && t_inc >= i_cfg.lp_delay) begin
                        o_ev.emit    = 1'b1;
                        o_ev.kind    = EV_LONG;
                        o_nxt.status = ST_LONG;
                    end
                end
            end
        end else if (i_kind == KIND_ROT_CLK) begin
            if (rise) begin
                // last key has no data partner
                if (i_has_next) begin
                    o_ev.emit = 1'b1;
                    o_ev.kind = i_next_idle ? EV_RIGHT : EV_LEFT;
                end
                o_nxt.status = ST_PRESS;
            end else if (fall) begin
                o_nxt.status = ST_IDLE;
            end
        end else if (i_kind == KIND_ROT_DAT) begin
            if (rise) begin
                o_nxt.status = ST_PRESS;
            end else if (fall) begin
                o_nxt.status = ST_IDLE;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/key_debounce_event_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// key debounce and event generator
// input channel: one beat per raw key sample (key number, pressed level) on
// i_in_valid / i_in_data, held off by o_in_stall. output channel: one beat per
// event (kind, key) on o_out_valid / o_out_data, held off by i_out_stall.
// a sample causes at most one event; samples for keys at or beyond NUM_KEYS
// are dropped with no effect.
// an event passes from its sample through the read register of the per-key state
// memory and the update stage into the output register. throughput: one sample per
// cycle while o_in_stall is low; the per-key state is read, updated and written
// back, with a forward from the write of the previous sample when it hits the same
// key or the rotary partner key. when the receiver stalls, the pending event waits
// in the output register; samples that give no event still pass, and the next
// event-producing sample waits in the update stage, raising o_in_stall until the
// output register frees up. reset clears the registers to their listed values and
// marks every key's state entry as idle with zero level and timer; no clearing pass
// is needed. configuration writes take effect at once; the user must make them only
// while the block is idle, as the block does not enforce it.

module key_debounce_event_generator
    import kdeg_pkg::*;
#(
    parameter int NUM_KEYS = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire t_in_beat             i_in_data,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    output t_out_beat                 o_out_data,
    input  wire logic                 i_out_stall,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int DEPTH = (NUM_KEYS < KEY_SPACE) ? NUM_KEYS : KEY_SPACE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [4:0] NK = 5'(NUM_KEYS);

    t_cfg                 r_cfg;
    logic [CFG_DAT_W-1:0] r_key_kinds;

    logic             r_s1_vld;
    logic [KEY_W-1:0] r_s1_key;
    logic             r_s1_pressed;
    logic             r_s1_has_next;
    logic             r_s1_next_mem;
    logic             r_fwd_a;
    logic             r_fwd_b;
    t_key_state       r_fwd_state;
    logic             r_out_vld;
    t_out_beat        r_out;

    logic             in_acc;
    logic             key_ok;
    logic [4:0]       next_key;
    logic             has_next;
    logic             next_mem;
    logic [AW-1:0]    rd_addr_a;
    logic [AW-1:0]    rd_addr_b;
    logic             s1_adv;
    logic             s1_wr;
    t_key_state       rd_a;
    logic [1:0]       rd_status_b;
    t_key_state       cur;
    logic [1:0]       next_status;
    logic [4:0]       kind_base;
    logic [KIND_W-1:0] kind;
    t_key_state       nxt;
    t_upd_ev          ev;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.upper     <= RST_UPPER;
            r_cfg.lower     <= RST_LOWER;
            r_cfg.ar_delay  <= RST_AR_DELAY;
            r_cfg.ar_period <= RST_AR_PERIOD;
            r_cfg.lp_delay  <= RST_LP_DELAY;
            r_key_kinds     <= RST_KINDS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_UPPER:     r_cfg.upper     <= i_cfg_data[LVL_W-1:0];
                CFG_LOWER:     r_cfg.lower     <= i_cfg_data[LVL_W-1:0];
                CFG_AR_DELAY:  r_cfg.ar_delay  <= i_cfg_data[TMR_W-1:0];
                CFG_AR_PERIOD: r_cfg.ar_period <= i_cfg_data[TMR_W-1:0];
                CFG_LP_DELAY:  r_cfg.lp_delay  <= i_cfg_data[TMR_W-1:0];
                CFG_KINDS:     r_key_kinds     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // read side: state of the key and status of its rotary partner
    assign in_acc    = i_in_valid && !o_in_stall;
    assign key_ok    = {2'b00, i_in_data.key_number} < NK;
    assign next_key  = {2'b00, i_in_data.key_number} + 5'd1;
    assign has_next  = next_key < NK;
    // a partner key past the sampled key range never leaves idle
    assign next_mem  = next_key < 5'(DEPTH);
    assign rd_addr_a = key_ok ? i_in_data.key_number[AW-1:0] : '0;
    assign rd_addr_b = next_mem ? next_key[AW-1:0] : '0;

    assign s1_adv     = !ev.emit || !r_out_vld || !i_out_stall;
    assign s1_wr      = r_s1_vld && s1_adv;
    assign o_in_stall = r_s1_vld && !s1_adv;

    kdeg_mem #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_mem (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd_en       (in_acc),
        .i_rd_addr_a   (rd_addr_a),
        .i_rd_addr_b   (rd_addr_b),
        .i_wr_en       (s1_wr),
        .i_wr_addr     (r_s1_key[AW-1:0]),
        .i_wr_data     (nxt),
        .o_rd_data_a   (rd_a),
        .o_rd_status_b (rd_status_b)
    );

    // stage 1 registers, with forward flags for a write landing on the read edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_fwd_a  <= 1'b0;
            r_fwd_b  <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= key_ok;
            r_fwd_a  <= s1_wr && (r_s1_key == i_in_data.key_number);
            r_fwd_b  <= s1_wr && ({2'b00, r_s1_key} == next_key);
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_key      <= i_in_data.key_number;
            r_s1_pressed  <= i_in_data.raw_pressed;
            r_s1_has_next <= has_next;
            r_s1_next_mem <= next_mem;
            r_fwd_state   <= nxt;
        end
    end

    assign cur         = r_fwd_a ? r_fwd_state : rd_a;
    assign next_status = !r_s1_next_mem ? ST_IDLE :
                         r_fwd_b ? r_fwd_state.status : rd_status_b;
    assign kind_base   = 5'({2'b00, r_s1_key} * 5'd3);
    assign kind        = r_key_kinds[kind_base +: KIND_W];

    kdeg_update u_update (
        .i_cur       (cur),
        .i_pressed   (r_s1_pressed),
        .i_kind      (kind),
        .i_has_next  (r_s1_has_next),
        .i_next_idle (next_status == ST_IDLE),
        .i_cfg       (r_cfg),
        .o_nxt       (nxt),
        .o_ev        (ev)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_wr && ev.emit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_wr && ev.emit) begin
            r_out.event_kind <= ev.kind;
            r_out.event_key  <= r_s1_key;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- sv/kdeg_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kdeg_chk
    import kdeg_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_stall,
    input wire logic                 o_out_valid,
    input wire t_out_beat            o_out_data,
    input wire logic                 i_out_stall
);

    // a pending event beat is not withdrawn while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("event beat dropped while stalled");

    // only defined event codes leave the block
    a_ev_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.event_kind <= EV_LEFT))
        else $error("undefined event code");

    // input is only held off behind a stalled event
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a pending event");

    // a fresh event follows an accepted sample through the memory read and the update stage
    a_ev_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("event without a matching sample");

    // nothing is pending straight after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("state not cleared by reset");

endmodule

bind key_debounce_event_generator kdeg_chk u_kdeg_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

`default_nettype wire

// ----- verif/key_debounce_event_generator_tb.sv -----
`timescale 1ns / 1ps

module key_debounce_event_generator_tb;
    import kdeg_pkg::*;

    localparam int N_KEYS         = KEY_SPACE;
    localparam int DRAIN_CYCLES   = 8;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;

    // kinds 5 to 7 only filter the level
    localparam logic [KIND_W-1:0] KIND_INERT = 3'd7;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 in_valid = 1'b0;
    t_in_beat             in_data  = '0;
    logic                 in_stall;
    logic                 out_valid;
    t_out_beat            out_data;
    logic                 out_stall = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    always #5 clk = ~clk;

    key_debounce_event_generator #(
        .NUM_KEYS(N_KEYS)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_data  (in_data),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out_data (out_data),
        .i_out_stall(out_stall),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // predictor copy of the block's registers and per-key state
    t_cfg                 cfg_now;
    logic [CFG_DAT_W-1:0] kinds_now;
    logic [LVL_W-1:0]     key_level [N_KEYS];
    logic [1:0]           key_state [N_KEYS];
    logic [TMR_W-1:0]     key_hold  [N_KEYS];

    t_in_beat  raw_samples    [$];
    t_out_beat pending_events [$];

    int gap_max      = 0;
    int stall_max    = 0;
    int holds_asked  = 0;
    int sample_cnt   = 0;
    int event_cnt    = 0;
    int err_cnt      = 0;
    int setting_cnt  = 0;
    int quiet_cycles = 0;

    function automatic void debounce_sample(t_in_beat s);
        int                k;
        logic [LVL_W-1:0]  lvl;
        logic [1:0]        st;
        logic [KIND_W-1:0] kd;
        logic [TMR_W-1:0]  t;
        logic              rise;
        logic              fall;
        logic              emit;
        logic [EV_W-1:0]   ev;
        t_out_beat         e;

        k = s.key_number;
        if (k >= N_KEYS) return;
        lvl = key_level[k];
        if (s.raw_pressed) lvl = lvl + ((LVL_MAX - lvl) >> 2);
        else lvl = lvl - (lvl >> 2);
        key_level[k] = lvl;

        st   = key_state[k];
        rise = (st == ST_IDLE) && (lvl > cfg_now.upper);
        fall = (st != ST_IDLE) && (lvl < cfg_now.lower);
        kd   = kinds_now[KIND_W*k +: KIND_W];
        emit = 1'b0;
        ev   = EV_DOWN;

        if (kd == KIND_PLAIN || kd == KIND_AUTOREP || kd == KIND_LONG) begin
            if (rise) begin
                emit         = 1'b1;
                ev           = EV_DOWN;
                key_hold[k]  = '0;
                key_state[k] = ST_PRESS;
            end else if (fall) begin
                // no up once a repeat or long event has gone out
                if (st == ST_PRESS) begin
                    emit = 1'b1;
                    ev   = EV_UP;
                end
                key_state[k] = ST_IDLE;
            end else if (st != ST_IDLE) begin
                t = key_hold[k];
                if (t != TMR_MAX) t = t + 1'b1;
                key_hold[k] = t;
                if (kd == KIND_AUTOREP) begin
                    if (st == ST_PRESS && t >= cfg_now.ar_delay) begin
                        emit         = 1'b1;
                        ev           = EV_REPEAT;
                        key_hold[k]  = '0;
                        key_state[k] = ST_AUTOREP;
                    end else if (st == ST_AUTOREP && t >= cfg_now.ar_period) begin
                        emit        = 1'b1;
                        ev          = EV_REPEAT;
                        key_hold[k] = '0;
                    end
                end else if (kd == KIND_LONG) begin
                    if (st == ST_PRESS && t >= cfg_now.lp_delay) begin
                        emit         = 1'b1;
                        ev           = EV_LONG;
                        key_state[k] = ST_LONG;
                    end
                end
            end
        end else if (kd == KIND_ROT_CLK) begin
            if (rise) begin
                // direction comes from the data key just above; the last key has none
                if (k + 1 < N_KEYS) begin
                    emit = 1'b1;
                    ev   = (key_state[k + 1] == ST_IDLE) ? EV_RIGHT : EV_LEFT;
                end
                key_state[k] = ST_PRESS;
            end else if (fall) begin
                key_state[k] = ST_IDLE;
            end
        end else if (kd == KIND_ROT_DAT) begin
            if (rise) key_state[k] = ST_PRESS;
            else if (fall) key_state[k] = ST_IDLE;
        end

        if (emit) begin
            e.event_kind = ev;
            e.event_key  = KEY_W'(k);
            pending_events.push_back(e);
        end
    endfunction

    // sender
    always @(posedge clk) begin : sender
        int gap_left;
        logic fire;

        fire = in_valid && !in_stall;
        if (fire) begin
            debounce_sample(in_data);
            sample_cnt++;
            gap_left = $urandom_range(0, gap_max);
        end
        if (!in_valid || fire) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (raw_samples.size() != 0) begin
                in_valid <= 1'b1;
                in_data  <= raw_samples.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver and event checker
    always @(posedge clk) begin : receiver
        int stall_left;
        int hold_left;
        int holds_done;
        t_out_beat want;

        if (out_valid && !out_stall) begin
            event_cnt++;
            if (pending_events.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("%0t: unexpected event kind %0d key %0d", $realtime,
                             out_data.event_kind, out_data.event_key);
            end else begin
                want = pending_events.pop_front();
                if (out_data.event_kind !== want.event_kind ||
                    out_data.event_key !== want.event_key) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: expected kind %0d key %0d, got kind %0d key %0d",
                                 $realtime, want.event_kind, want.event_key,
                                 out_data.event_kind, out_data.event_key);
                end
            end
            stall_left = $urandom_range(0, stall_max);
        end
        if (holds_done != holds_asked) begin
            holds_done++;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d events outstanding",
                     quiet_cycles, pending_events.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // block is idle once every event is in and the pipe has flushed
    task automatic wait_idle();
        do @(negedge clk);
        while (raw_samples.size() != 0 || in_valid || pending_events.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_UPPER:     cfg_now.upper     = val[LVL_W-1:0];
            CFG_LOWER:     cfg_now.lower     = val[LVL_W-1:0];
            CFG_AR_DELAY:  cfg_now.ar_delay  = val[TMR_W-1:0];
            CFG_AR_PERIOD: cfg_now.ar_period = val[TMR_W-1:0];
            CFG_LP_DELAY:  cfg_now.lp_delay  = val[TMR_W-1:0];
            CFG_KINDS:     kinds_now         = val;
            default: ;
        endcase
    endtask

    task automatic load_setting(input logic [LVL_W-1:0] upper, input logic [LVL_W-1:0] lower,
                                input logic [TMR_W-1:0] ar_delay,
                                input logic [TMR_W-1:0] ar_period,
                                input logic [TMR_W-1:0] lp_delay,
                                input logic [CFG_DAT_W-1:0] kinds);
        wait_idle();
        write_reg(CFG_UPPER, CFG_DAT_W'(upper));
        write_reg(CFG_LOWER, CFG_DAT_W'(lower));
        write_reg(CFG_AR_DELAY, CFG_DAT_W'(ar_delay));
        write_reg(CFG_AR_PERIOD, CFG_DAT_W'(ar_period));
        write_reg(CFG_LP_DELAY, CFG_DAT_W'(lp_delay));
        write_reg(CFG_KINDS, kinds);
        // indexes past the register list must be dropped
        for (int i = CFG_KINDS + 1; i < 2 ** CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), CFG_DAT_W'($urandom));
        @(posedge clk);
        cfg_we <= 1'b0;
        setting_cnt++;
    endtask

    task automatic push_sample(input int key, input logic pressed, input int times);
        t_in_beat s;

        s.key_number  = KEY_W'(key);
        s.raw_pressed = pressed;
        repeat (times) raw_samples.push_back(s);
    endtask

    function automatic logic [CFG_DAT_W-1:0] random_kinds();
        logic [CFG_DAT_W-1:0] v;

        for (int k = 0; k < N_KEYS; k++) begin
            if ($urandom_range(0, 9) < 8) v[KIND_W*k +: KIND_W] = KIND_W'($urandom_range(0, 4));
            else v[KIND_W*k +: KIND_W] = KIND_W'($urandom_range(5, 7));
        end
        return v;
    endfunction

    // mostly bursts of one key at one level so levels cross the thresholds
    task automatic queue_traffic(input int n_items);
        int made;
        int run;

        made = 0;
        while (made < n_items) begin
            if ($urandom_range(0, 9) < 8) begin
                run = $urandom_range(1, 12);
                push_sample($urandom_range(0, N_KEYS - 1), 1'($urandom_range(0, 1)), run);
            end else begin
                run = 1;
                raw_samples.push_back(t_in_beat'(4'($urandom_range(0, 15))));
            end
            made += run;
        end
    endtask

    initial begin : stimulus
        for (int k = 0; k < N_KEYS; k++) begin
            key_level[k] = '0;
            key_state[k] = ST_IDLE;
            key_hold[k]  = '0;
        end
        cfg_now.upper     = RST_UPPER;
        cfg_now.lower     = RST_LOWER;
        cfg_now.ar_delay  = RST_AR_DELAY;
        cfg_now.ar_period = RST_AR_PERIOD;
        cfg_now.lp_delay  = RST_LP_DELAY;
        kinds_now         = RST_KINDS;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // thresholds at zero: one pressed beat presses and nothing releases
        load_setting(8'd0, 8'd0, 16'd1, 16'd0, 16'd2,
                     {KIND_ROT_CLK, KIND_INERT, KIND_ROT_CLK, KIND_ROT_DAT,
                      KIND_ROT_CLK, KIND_LONG, KIND_AUTOREP, KIND_PLAIN});
        push_sample(4, 1'b1, 1);
        push_sample(3, 1'b1, 1);    // data key held: left
        push_sample(5, 1'b1, 1);    // inert key above stays idle: right
        push_sample(6, 1'b1, 1);
        push_sample(7, 1'b1, 1);    // last key has no partner
        push_sample(0, 1'b1, 2);
        push_sample(1, 1'b1, 3);
        push_sample(2, 1'b1, 4);

        // thresholds at full scale: every held key drops, nothing presses
        load_setting(8'd255, 8'd255, 16'd1, 16'd0, 16'd2, kinds_now);
        for (int k = 0; k < N_KEYS; k++) push_sample(k, 1'b0, 1);
        push_sample(0, 1'b1, 2);

        gap_max   = 10;
        stall_max = 10;
        load_setting(RST_UPPER, RST_LOWER, TMR_W'($urandom_range(0, 20)),
                     TMR_W'($urandom_range(0, 8)), TMR_W'($urandom_range(0, 30)),
                     random_kinds());
        queue_traffic(70);

        gap_max   = 0;
        load_setting(LVL_W'($urandom_range(120, 250)), LVL_W'($urandom_range(5, 100)),
                     TMR_W'($urandom_range(0, 15)), TMR_W'($urandom_range(0, 15)),
                     TMR_W'($urandom_range(0, 15)), random_kinds());
        queue_traffic(70);

        gap_max   = 10;
        stall_max = 0;
        load_setting(LVL_W'($urandom_range(0, 255)), LVL_W'($urandom_range(0, 255)),
                     TMR_W'($urandom_range(0, 6)), TMR_W'($urandom_range(0, 6)),
                     TMR_W'($urandom_range(0, 6)), random_kinds());
        queue_traffic(70);

        // every held beat repeats while the receiver holds off
        gap_max   = 0;
        load_setting(RST_UPPER, RST_LOWER, 16'd0, 16'd0, 16'd0, {N_KEYS{KIND_AUTOREP}});
        holds_asked++;
        queue_traffic(80);

        gap_max   = 10;
        stall_max = 10;
        load_setting(LVL_W'($urandom_range(150, 230)), LVL_W'($urandom_range(20, 120)),
                     TMR_W'($urandom_range(0, 40)), TMR_W'($urandom_range(0, 40)),
                     TMR_W'($urandom_range(0, 40)), random_kinds());
        queue_traffic(70);

        wait_idle();
        $display("%0d key samples over %0d register settings, %0d events checked, %0d errors",
                 sample_cnt, setting_cnt, event_cnt, err_cnt);
        $display("covered all key kinds, threshold extremes and a %0d-cycle receiver hold-off",
                 LONG_HOLD);
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
